[rtl/core/afc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the 2D affine transform composer
// Action codes, controller states, command/status bundles, Q-format constants
// and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package afc_pkg;

  typedef enum logic [2:0] {
    ACT_IDENTITY  = 3'd0,
    ACT_SCALE     = 3'd1,
    ACT_ROTATE    = 3'd2,
    ACT_TRANSLATE = 3'd3,
    ACT_SHEAR_X   = 3'd4,
    ACT_SHEAR_Y   = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_REDUCE,
    ST_FOLD,
    ST_RADIAN,
    ST_CORDIC,
    ST_COSSIN,
    ST_MUL_A,
    ST_MUL_B,
    ST_SETTLE,
    ST_FINISH
  } state_e;

  localparam int unsigned ATAN_ENTRIES = 30;
  localparam int unsigned STEP_W       = 5;   // indexes the arctangent table
  localparam int unsigned REDUCE_STEPS = 8;
  localparam int unsigned RED_K_W      = 3;

  localparam logic signed [31:0] ONE_Q16         = 32'sh0001_0000;
  localparam logic        [32:0] DEG360_U33      = 33'd23592960;
  localparam logic signed [25:0] DEG360_S26      = 26'sd23592960;
  localparam logic signed [25:0] DEG180_S26      = 26'sd11796480;
  localparam logic signed [25:0] DEG90_S26       = 26'sd5898240;
  // 92 turns: lifts any 32-bit angle to a non-negative value
  localparam logic signed [33:0] REDUCE_OFFSET   = 34'sd2170552320;
  localparam logic signed [25:0] PI_OVER_180_Q30 = 26'sd18740330;
  localparam logic signed [33:0] CORDIC_X0_Q30   = 34'sd652032874;

  typedef struct packed {
    logic                  capture;
    logic                  red_init;
    logic                  red_step;
    logic [RED_K_W-1:0]    red_k;
    logic                  fold;
    logic                  radian;
    logic                  cordic_step;
    logic [STEP_W-1:0]     cordic_i;
    logic                  cossin;
    logic                  mul_a;
    logic                  mul_b;
    logic                  settle;
    logic                  row;
    logic [1:0]            col;
    logic                  ident_load;
    logic                  out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    out_busy;
  } sts_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/affine_transform_composer_2d.sv]
`timescale 1ns / 1ps
// Scale, translate and shear pass each of the six entries through the shared
//   multiplier in the states MUL_A, MUL_B and SETTLE; rotate does the same after
//   8 angle reduction steps and one CORDIC iteration per cycle; identity and unused
//   action codes go straight to the output register.
// Throughput: one item at a time; a new item is accepted once the previous result
//   is loaded into the output register. Async active-low reset returns the matrix to identity.
// ----------------------------------------------------------------------------
// affine_transform_composer_2d: 2D affine matrix composer
// Premultiplies a Q16.16 affine matrix by scale, rotate, translate and shear
// operations, or resets it to identity, and emits all six entries after every operation.
// ----------------------------------------------------------------------------
module affine_transform_composer_2d #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // action[2:0], arg_a[34:3], arg_b[66:35], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata    // m00, m01, m02, m10, m11, m12, 32 bits each
);

  afc_pkg::cmd_t cmd;
  afc_pkg::sts_t sts;

  afc_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // result register is never reloaded while an earlier result still waits
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("output register overwritten while stalled");

  // one item at a time: an input transfer closes the input side
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // datapath phases never overlap
  a_phase_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.red_step, cmd.cordic_step, cmd.mul_a, cmd.mul_b, cmd.settle,
              cmd.out_load}))
    else $error("overlapping datapath commands");

endmodule

[rtl/core/afc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_ctrl: sequencer for the affine transform composer
// Steps the angle reduction, CORDIC iterations and the per-entry multiply
// schedule, and hands the finished matrix to the output register.
// ----------------------------------------------------------------------------
module afc_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  afc_pkg::sts_t  sts_i,
  output afc_pkg::cmd_t  cmd_o
);

  afc_pkg::state_e                state_q, state_d;
  logic [afc_pkg::STEP_W-1:0]     cnt_q, cnt_d;
  logic                           row_q, row_d;
  logic [1:0]                     col_q, col_d;

  localparam logic [afc_pkg::STEP_W-1:0] CordicLast = afc_pkg::STEP_W'(CORDIC_STEPS - 1);
  localparam logic [afc_pkg::STEP_W-1:0] ReduceFirst =
    afc_pkg::STEP_W'(afc_pkg::REDUCE_STEPS - 1);
  localparam logic [afc_pkg::STEP_W-1:0] CntOne = afc_pkg::STEP_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      afc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = afc_pkg::ST_DISPATCH;
      end
      afc_pkg::ST_DISPATCH: begin
        unique case (sts_i.action)
          afc_pkg::ACT_IDENTITY:  state_d = afc_pkg::ST_FINISH;
          afc_pkg::ACT_ROTATE:    state_d = afc_pkg::ST_REDUCE;
          afc_pkg::ACT_SCALE,
          afc_pkg::ACT_TRANSLATE,
          afc_pkg::ACT_SHEAR_X,
          afc_pkg::ACT_SHEAR_Y:   state_d = afc_pkg::ST_MUL_A;
          default:                state_d = afc_pkg::ST_FINISH;
        endcase
      end
      afc_pkg::ST_REDUCE: begin
        if (cnt_q == '0) state_d = afc_pkg::ST_FOLD;
      end
      afc_pkg::ST_FOLD:   state_d = afc_pkg::ST_RADIAN;
      afc_pkg::ST_RADIAN: state_d = afc_pkg::ST_CORDIC;
      afc_pkg::ST_CORDIC: begin
        if (cnt_q == CordicLast) state_d = afc_pkg::ST_COSSIN;
      end
      afc_pkg::ST_COSSIN: state_d = afc_pkg::ST_MUL_A;
      afc_pkg::ST_MUL_A:  state_d = afc_pkg::ST_MUL_B;
      afc_pkg::ST_MUL_B:  state_d = afc_pkg::ST_SETTLE;
      afc_pkg::ST_SETTLE: begin
        if (row_q && col_q == 2'd2) state_d = afc_pkg::ST_FINISH;
        else                        state_d = afc_pkg::ST_MUL_A;
      end
      afc_pkg::ST_FINISH: begin
        if (!sts_i.out_busy) state_d = afc_pkg::ST_IDLE;
      end
      default: state_d = afc_pkg::ST_IDLE;
    endcase
  end

  // step counter, row and column of the entry being formed
  always_comb begin
    cnt_d = cnt_q;
    row_d = row_q;
    col_d = col_q;
    unique case (state_q)
      afc_pkg::ST_DISPATCH: begin
        cnt_d = ReduceFirst;
        row_d = 1'b0;
        col_d = 2'd0;
      end
      afc_pkg::ST_REDUCE: cnt_d = cnt_q - CntOne;
      afc_pkg::ST_RADIAN: cnt_d = '0;
      afc_pkg::ST_CORDIC: cnt_d = cnt_q + CntOne;
      afc_pkg::ST_SETTLE: begin
        row_d = ~row_q;
        if (row_q) col_d = col_q + 2'd1;
      end
      default: ;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.red_k       = cnt_q[afc_pkg::RED_K_W-1:0];
    cmd_o.cordic_i    = cnt_q;
    cmd_o.row         = row_q;
    cmd_o.col         = col_q;
    in_ready_o        = 1'b0;
    unique case (state_q)
      afc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      afc_pkg::ST_DISPATCH: begin
        cmd_o.red_init   = 1'b1;
        cmd_o.ident_load = (sts_i.action == afc_pkg::ACT_IDENTITY);
      end
      afc_pkg::ST_REDUCE: cmd_o.red_step    = 1'b1;
      afc_pkg::ST_FOLD:   cmd_o.fold        = 1'b1;
      afc_pkg::ST_RADIAN: cmd_o.radian      = 1'b1;
      afc_pkg::ST_CORDIC: cmd_o.cordic_step = 1'b1;
      afc_pkg::ST_COSSIN: cmd_o.cossin      = 1'b1;
      afc_pkg::ST_MUL_A:  cmd_o.mul_a       = 1'b1;
      afc_pkg::ST_MUL_B:  cmd_o.mul_b       = 1'b1;
      afc_pkg::ST_SETTLE: cmd_o.settle      = 1'b1;
      afc_pkg::ST_FINISH: cmd_o.out_load    = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afc_pkg::ST_IDLE;
      cnt_q   <= '0;
      row_q   <= 1'b0;
      col_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

endmodule

[rtl/core/afc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_dp: datapath of the affine transform composer
// Matrix registers, angle reduction, CORDIC, one shared 32x32 multiplier with
// round/saturate, and the output register.
// ----------------------------------------------------------------------------
module afc_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  afc_pkg::cmd_t  cmd_i,
  output afc_pkg::sts_t  sts_o,
  input  logic [71:0]    in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [191:0]   out_data_o
);

  // matrix, column 0 is always the column being worked on (columns rotate)
  logic signed [31:0]  m_q [2][3];
  logic signed [31:0]  n0_q;

  afc_pkg::action_e    action_q;
  logic signed [31:0]  a_q, b_q;

  logic        [32:0]  red_q;
  logic signed [25:0]  deg_q;
  logic                flip_q;
  logic signed [33:0]  x_q, y_q, z_q;
  logic signed [31:0]  c_q, s_q;

  logic signed [63:0]  prod_q, acc_q;
  logic                out_valid_q;
  logic        [191:0] out_data_q;

  // angle reduction step
  logic signed [33:0]  red_init;
  logic        [32:0]  red_sub;
  always_comb begin
    red_init = 34'(a_q) + afc_pkg::REDUCE_OFFSET;
    red_sub  = afc_pkg::DEG360_U33 << cmd_i.red_k;
  end

  // fold into [-90, 90] degrees
  logic signed [25:0]  fold_d0, fold_d1, fold_deg;
  logic                fold_flip;
  always_comb begin
    fold_d0   = {1'b0, red_q[24:0]};
    fold_d1   = (fold_d0 >= afc_pkg::DEG180_S26) ? fold_d0 - afc_pkg::DEG360_S26 : fold_d0;
    fold_deg  = fold_d1;
    fold_flip = 1'b0;
    if (fold_d1 > afc_pkg::DEG90_S26) begin
      fold_deg  = fold_d1 - afc_pkg::DEG180_S26;
      fold_flip = 1'b1;
    end else if (fold_d1 < -afc_pkg::DEG90_S26) begin
      fold_deg  = fold_d1 + afc_pkg::DEG180_S26;
      fold_flip = 1'b1;
    end
  end

  // degrees Q16.16 to radians Q2.30
  logic signed [51:0]  rad_p, rad_r;
  always_comb begin
    rad_p = 52'(deg_q) * 52'(afc_pkg::PI_OVER_180_Q30);
    rad_r = (rad_p + 52'sd32768) >>> 16;
  end

  // CORDIC micro-rotation
  logic signed [33:0]  xs, ys, atan_v;
  always_comb begin
    xs     = x_q >>> cmd_i.cordic_i;
    ys     = y_q >>> cmd_i.cordic_i;
    atan_v = signed'({2'b00, afc_pkg::atan_q30(cmd_i.cordic_i)});
  end

  // cosine and sine to Q16.16
  logic signed [33:0]  cx, sy;
  always_comb begin
    cx = (x_q + 34'sd8192) >>> 14;
    sy = (y_q + 34'sd8192) >>> 14;
    if (flip_q) begin
      cx = -cx;
      sy = -sy;
    end
  end

  // operand selection: new[r] = coef_a * m[r] + coef_b * op_b
  logic signed [31:0]  own, other, coef_a, coef_b, op_b;
  always_comb begin
    own    = cmd_i.row ? m_q[1][0] : m_q[0][0];
    other  = cmd_i.row ? m_q[0][0] : m_q[1][0];
    coef_a = afc_pkg::ONE_Q16;
    coef_b = '0;
    op_b   = other;
    unique case (action_q)
      afc_pkg::ACT_SCALE:  coef_a = cmd_i.row ? b_q : a_q;
      afc_pkg::ACT_ROTATE: begin
        coef_a = c_q;
        coef_b = cmd_i.row ? s_q : -s_q;
      end
      afc_pkg::ACT_TRANSLATE: begin
        op_b   = afc_pkg::ONE_Q16;
        coef_b = (cmd_i.col == 2'd2) ? (cmd_i.row ? b_q : a_q) : '0;
      end
      afc_pkg::ACT_SHEAR_X: coef_b = cmd_i.row ? '0 : a_q;
      afc_pkg::ACT_SHEAR_Y: coef_b = cmd_i.row ? a_q : '0;
      default: ;
    endcase
  end

  logic signed [31:0]  mul_x, mul_y;
  logic signed [63:0]  mul_p;
  always_comb begin
    mul_x = cmd_i.mul_b ? coef_b : coef_a;
    mul_y = cmd_i.mul_b ? op_b : own;
    mul_p = mul_x * mul_y;
  end

  // Q32.32 sum to Q16.16, round and saturate
  logic signed [64:0]  sum, rnd;
  logic signed [31:0]  settled;
  always_comb begin
    sum = 65'(acc_q) + 65'(prod_q);
    rnd = (sum + 65'sd32768) >>> 16;
    if (rnd > 65'sd2147483647)       settled = 32'sh7FFF_FFFF;
    else if (rnd < -65'sd2147483648) settled = 32'sh8000_0000;
    else                             settled = rnd[31:0];
  end

  // matrix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q[0][0] <= afc_pkg::ONE_Q16;
      m_q[0][1] <= '0;
      m_q[0][2] <= '0;
      m_q[1][0] <= '0;
      m_q[1][1] <= afc_pkg::ONE_Q16;
      m_q[1][2] <= '0;
    end else if (cmd_i.ident_load) begin
      m_q[0][0] <= afc_pkg::ONE_Q16;
      m_q[0][1] <= '0;
      m_q[0][2] <= '0;
      m_q[1][0] <= '0;
      m_q[1][1] <= afc_pkg::ONE_Q16;
      m_q[1][2] <= '0;
    end else if (cmd_i.settle && cmd_i.row) begin
      m_q[0][0] <= m_q[0][1];
      m_q[0][1] <= m_q[0][2];
      m_q[0][2] <= n0_q;
      m_q[1][0] <= m_q[1][1];
      m_q[1][1] <= m_q[1][2];
      m_q[1][2] <= settled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= afc_pkg::action_e'(in_data_i[2:0]);
      a_q      <= in_data_i[34:3];
      b_q      <= in_data_i[66:35];
    end
    if (cmd_i.red_init) red_q <= red_init[32:0];
    else if (cmd_i.red_step && red_q >= red_sub) red_q <= red_q - red_sub;
    if (cmd_i.fold) begin
      deg_q  <= fold_deg;
      flip_q <= fold_flip;
    end
    if (cmd_i.radian) begin
      x_q <= afc_pkg::CORDIC_X0_Q30;
      y_q <= '0;
      z_q <= rad_r[33:0];
    end else if (cmd_i.cordic_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.cossin) begin
      c_q <= cx[31:0];
      s_q <= sy[31:0];
    end
    if (cmd_i.mul_a) prod_q <= mul_p;
    if (cmd_i.mul_b) begin
      acc_q  <= prod_q;
      prod_q <= mul_p;
    end
    if (cmd_i.settle && !cmd_i.row) n0_q <= settled;
    if (cmd_i.out_load) begin
      out_data_q <= {m_q[1][2], m_q[1][1], m_q[1][0], m_q[0][2], m_q[0][1], m_q[0][0]};
    end
  end

  assign sts_o.action   = action_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule
